// ----- rtl/pcc_pkg.sv -----
package pcc_pkg;

  // Word format: signed fixed point, FRAC_BITS fraction bits
  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;

  // Error is kept exact in one extra bit, error differences in two
  localparam int ERR_W      = WORD_BITS + 1;
  localparam int DIFF_W     = WORD_BITS + 2;
  localparam int MAG_W      = WORD_BITS + 1;
  localparam int QBITS      = WORD_BITS - 1;
  localparam int LIMIT_W    = WORD_BITS - 1;
  localparam int PROD_W     = ERR_W + WORD_BITS;

  // Stream and configuration port widths
  localparam int CFG_ADDR_W = 3;
  localparam int S_TDATA_W  = ((2 * WORD_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((WORD_BITS + 7) / 8) * 8;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

  // Request kinds carried in tuser
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_OUT_MIN,
    REG_OUT_MAX,
    REG_INT_LIMIT,
    REG_SETPOINT,
    REG_ENABLE
  } cfg_reg_t;

  // Operand pairs for the shared fixed-point multiplier
  typedef enum logic [1:0] {
    MS_ERR_DT,
    MS_KP_ERR,
    MS_KI_INT,
    MS_KD_DER
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL_I,
    S_MUL_P,
    S_MUL_KI,
    S_DIV_WAIT,
    S_MUL_D,
    S_SUM,
    S_CLAMP,
    S_OUT,
    S_OUT_HELD
  } state_t;

  typedef struct packed {
    logic     in_load;
    logic     clear_loop;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     div_start;
    logic     int_update;
    logic     p_store;
    logic     i_store;
    logic     d_store;
    logic     sum_store;
    logic     clamp_store;
    logic     out_load;
    logic     out_held;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic hold;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/pcc_div.sv -----
module pcc_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pcc_pkg::MAG_W-1:0]      mag,
  input  logic                           neg,
  input  logic [pcc_pkg::QBITS-1:0]      divisor,
  output logic                           done,
  output logic [pcc_pkg::WORD_BITS-1:0]  quot
);
  import pcc_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int HI_W  = NUM_W - QBITS;
  localparam int CW    = (HI_W > QBITS) ? HI_W : QBITS;
  localparam int CNT_W = $clog2(QBITS + 1);

  logic [NUM_W-1:0]  num;
  logic [HI_W-1:0]   hi;
  logic [CW-1:0]     hi_ext;
  logic [CW-1:0]     dv_ext;
  logic              too_big;

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [QBITS-1:0]  rem;
  logic [QBITS-1:0]  lo;
  logic [QBITS-1:0]  q;
  logic [QBITS-1:0]  dv;
  logic              sat;
  logic              qneg;

  logic [QBITS:0]    trial;
  logic [QBITS:0]    trial_sub;
  logic              fits;
  logic [WORD_BITS-1:0] qext;

  // Dividend is |diff| scaled up by the fraction bits
  assign num     = {mag, {FRAC_BITS{1'b0}}};
  assign hi      = num[NUM_W-1:QBITS];
  assign hi_ext  = CW'(hi);
  assign dv_ext  = CW'(divisor);
  // Quotient would not fit the word when the top part already reaches the divisor
  assign too_big = (hi_ext >= dv_ext);

  // One restoring step per cycle
  assign trial     = {rem, lo[QBITS-1]};
  assign trial_sub = trial - {1'b0, dv};
  assign fits      = (trial >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= !too_big;
      done <= too_big;
      cnt  <= CNT_W'(QBITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= QBITS'(hi_ext);
      lo   <= num[QBITS-1:0];
      q    <= '0;
      dv   <= divisor;
      sat  <= too_big;
      qneg <= neg;
    end else if (busy) begin
      rem <= fits ? trial_sub[QBITS-1:0] : trial[QBITS-1:0];
      lo  <= lo << 1;
      q   <= {q[QBITS-2:0], fits};
    end
  end

  // Signed, saturated quotient
  assign qext = {1'b0, q};
  always_comb begin
    if (sat) begin
      quot = qneg ? WORD_MIN : WORD_MAX;
    end else begin
      quot = qneg ? (-qext) : qext;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider flags done while still iterating");

endmodule

// ----- rtl/pcc_dp.sv -----
module pcc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pcc_pkg::ctrl_cmd_t                cmd,
  output pcc_pkg::ctrl_stat_t               status,
  input  logic [pcc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pcc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                              m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [pcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcc_pkg::WORD_BITS-1:0]     cfg_data
);
  import pcc_pkg::*;

  localparam int W = WORD_BITS;

  // Configuration registers
  logic [W-1:0]       kp, ki, kd, out_min, out_max, setpoint;
  logic [LIMIT_W-1:0] int_limit;
  logic               enable;
  logic               cfg_clear;

  // Loop state
  logic [W-1:0]       integral;
  logic [ERR_W-1:0]   last_error;
  logic [W-1:0]       drive_value;

  // Request holding registers
  logic               opcode;
  logic [ERR_W-1:0]   err;
  logic [W-1:0]       dt;
  logic [W-1:0]       meas;
  logic [W-1:0]       step_in;

  // Multiplier
  logic [ERR_W-1:0]   mul_a;
  logic [W-1:0]       mul_b;
  logic [ERR_W-1:0]   ua;
  logic [W-1:0]       ub;
  logic [PROD_W-1:0]  prod_c;
  logic [PROD_W-1:0]  prod;
  logic               pneg;
  logic               p_over;
  logic [W-1:0]       qm;
  logic [W-1:0]       mulq;

  // Partial terms
  logic [W-1:0]       p_term, i_term, d_term;
  logic [W-1:0]       sum_r;

  // Divider hookup
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  diff_abs;
  logic [W-1:0]       deriv;
  logic               div_done;

  // Integral and sum paths
  logic [W:0]         acc;
  logic [W:0]         lim_pos;
  logic [W:0]         lim_neg;
  logic [W-1:0]       acc_clamped;
  logic [W+1:0]       sum3;
  logic [W-1:0]       sum_sat;
  logic [W-1:0]       clamped;

  // Output register
  logic [W-1:0]       out_drive;
  logic               out_held;
  logic               out_valid;

  assign meas    = s_axis_tdata[W-1:0];
  assign step_in = s_axis_tdata[2*W-1:W];

  // Configuration writes; disabling the loop clears its state
  assign cfg_clear = cfg_we && (cfg_reg_t'(cfg_addr) == REG_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      kp        <= '0;
      ki        <= '0;
      kd        <= '0;
      out_min   <= '0;
      out_max   <= '0;
      int_limit <= '0;
      setpoint  <= '0;
      enable    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_KP:        kp        <= cfg_data;
        REG_KI:        ki        <= cfg_data;
        REG_KD:        kd        <= cfg_data;
        REG_OUT_MIN:   out_min   <= cfg_data;
        REG_OUT_MAX:   out_max   <= cfg_data;
        REG_INT_LIMIT: int_limit <= cfg_data[LIMIT_W-1:0];
        REG_SETPOINT:  setpoint  <= cfg_data;
        REG_ENABLE:    enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture request; error is formed exactly in one extra bit
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      opcode <= s_axis_tuser;
      dt     <= step_in;
      err    <= {setpoint[W-1], setpoint} - {meas[W-1], meas};
    end
  end

  assign status.op_clear = (opcode == OP_CLEAR);
  assign status.hold     = !enable || dt[W-1] || (dt == '0);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || m_axis_tready;

  // Shared multiplier: magnitudes in, sign kept aside
  always_comb begin
    case (cmd.mul_sel)
      MS_ERR_DT: begin
        mul_a = err;
        mul_b = dt;
      end
      MS_KP_ERR: begin
        mul_a = err;
        mul_b = kp;
      end
      MS_KI_INT: begin
        mul_a = {integral[W-1], integral};
        mul_b = ki;
      end
      MS_KD_DER: begin
        mul_a = {deriv[W-1], deriv};
        mul_b = kd;
      end
      default: begin
        mul_a = err;
        mul_b = dt;
      end
    endcase
  end

  assign ua     = mul_a[ERR_W-1] ? (-mul_a) : mul_a;
  assign ub     = mul_b[W-1] ? (-mul_b) : mul_b;
  assign prod_c = ua * ub;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= prod_c;
      pneg <= mul_a[ERR_W-1] ^ mul_b[W-1];
    end
  end

  // Drop fraction bits (toward zero) and saturate
  assign p_over = |prod[PROD_W-1:FRAC_BITS+W-1];
  assign qm     = {1'b0, prod[FRAC_BITS+W-2:FRAC_BITS]};
  always_comb begin
    if (p_over) begin
      mulq = pneg ? WORD_MIN : WORD_MAX;
    end else begin
      mulq = pneg ? (-qm) : qm;
    end
  end

  // Integral accumulate and clamp to +-limit
  assign acc     = {integral[W-1], integral} + {mulq[W-1], mulq};
  assign lim_pos = {2'b00, int_limit};
  assign lim_neg = -lim_pos;
  always_comb begin
    if ($signed(acc) > $signed(lim_pos)) begin
      acc_clamped = lim_pos[W-1:0];
    end else if ($signed(acc) < $signed(lim_neg)) begin
      acc_clamped = lim_neg[W-1:0];
    end else begin
      acc_clamped = acc[W-1:0];
    end
  end

  // Error change for the derivative
  assign diff     = {err[ERR_W-1], err} - {last_error[ERR_W-1], last_error};
  assign diff_abs = diff[DIFF_W-1] ? (-diff) : diff;

  pcc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .mag     (diff_abs[MAG_W-1:0]),
    .neg     (diff[DIFF_W-1]),
    .divisor (dt[QBITS-1:0]),
    .done    (div_done),
    .quot    (deriv)
  );

  // P + I + D, saturated to the word
  assign sum3 = {{2{p_term[W-1]}}, p_term} + {{2{i_term[W-1]}}, i_term}
              + {{2{d_term[W-1]}}, d_term};
  always_comb begin
    if ($signed(sum3) > $signed({2'b00, WORD_MAX})) begin
      sum_sat = WORD_MAX;
    end else if ($signed(sum3) < $signed({2'b11, WORD_MIN})) begin
      sum_sat = WORD_MIN;
    end else begin
      sum_sat = sum3[W-1:0];
    end
  end

  // Output clamp, upper limit tested first
  always_comb begin
    if ($signed(sum_r) > $signed(out_max)) begin
      clamped = out_max;
    end else if ($signed(sum_r) < $signed(out_min)) begin
      clamped = out_min;
    end else begin
      clamped = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.p_store)   p_term <= mulq;
    if (cmd.i_store)   i_term <= mulq;
    if (cmd.d_store)   d_term <= mulq;
    if (cmd.sum_store) sum_r  <= sum_sat;
  end

  // Loop state
  always_ff @(posedge clk) begin
    if (rst || cfg_clear || cmd.clear_loop) begin
      integral    <= '0;
      last_error  <= '0;
      drive_value <= '0;
    end else begin
      if (cmd.int_update) begin
        integral <= acc_clamped;
      end
      if (cmd.clamp_store) begin
        drive_value <= clamped;
        last_error  <= err;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_drive <= drive_value;
      out_held  <= cmd.out_held;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_TDATA_W'(out_drive);
  assign m_axis_tuser  = out_held;

endmodule

// ----- rtl/pcc_ctrl.sv -----
module pcc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  pcc_pkg::ctrl_stat_t  status,
  output pcc_pkg::ctrl_cmd_t   cmd
);
  import pcc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.op_clear || status.hold) begin
          state_next = S_OUT_HELD;
        end else begin
          state_next = S_MUL_I;
        end
      end
      S_MUL_I:    state_next = S_MUL_P;
      S_MUL_P:    state_next = S_MUL_KI;
      S_MUL_KI:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (status.div_done) state_next = S_MUL_D;
      end
      S_MUL_D:    state_next = S_SUM;
      S_SUM:      state_next = S_CLAMP;
      S_CLAMP:    state_next = S_OUT;
      S_OUT, S_OUT_HELD: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MS_ERR_DT;
    s_axis_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.in_load   = s_axis_tvalid;
      end
      S_DECIDE: begin
        if (status.op_clear) begin
          cmd.clear_loop = 1'b1;
        end else if (!status.hold) begin
          cmd.mul_load  = 1'b1;
          cmd.mul_sel   = MS_ERR_DT;
          cmd.div_start = 1'b1;
        end
      end
      S_MUL_I: begin
        cmd.int_update = 1'b1;
        cmd.mul_load   = 1'b1;
        cmd.mul_sel    = MS_KP_ERR;
      end
      S_MUL_P: begin
        cmd.p_store  = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.mul_sel  = MS_KI_INT;
      end
      S_MUL_KI: begin
        cmd.i_store = 1'b1;
      end
      S_DIV_WAIT: begin
        cmd.mul_load = status.div_done;
        cmd.mul_sel  = MS_KD_DER;
      end
      S_MUL_D: begin
        cmd.d_store = 1'b1;
      end
      S_SUM: begin
        cmd.sum_store = 1'b1;
      end
      S_CLAMP: begin
        cmd.clamp_store = 1'b1;
      end
      S_OUT: begin
        cmd.out_load = status.out_free;
      end
      S_OUT_HELD: begin
        cmd.out_load = status.out_free;
        cmd.out_held = 1'b1;
      end
      default: ;
    endcase
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded while output register still occupied");

  a_deriv_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_load && cmd.mul_sel == MS_KD_DER) |-> status.div_done)
    else $error("derivative product started before the quotient was ready");

  a_accept_decides: assert property (@(posedge clk) disable iff (rst)
    cmd.in_load |=> state == S_DECIDE)
    else $error("accepted request did not move to decode");

endmodule

// ----- rtl/pid_controller_clamped_top.sv -----
// PID controller with integral clamp, signed Q16.16 arithmetic.
// Input stream: s_axis_tdata = {step_time, measured}, s_axis_tuser = opcode
// (0 = control step, 1 = clear loop state). Output stream: m_axis_tdata = drive,
// m_axis_tuser = held. Exactly one result per request, in order.
// Configuration: cfg_we/cfg_addr/cfg_data write kp, ki, kd, out_min, out_max,
// integral_limit, setpoint, enable (indexes 0..7); write only while idle.
// A clear or hold request goes from decode straight to the output register; a
// full control step runs the products and waits on the 31-step restoring
// divider for the derivative (it skips the steps when the quotient saturates).
// The four products share one multiplier.
// One request is worked at a time; s_axis_tready is high only while idle.
// A finished result sits in an output register, and the next request is taken
// while it waits; a stalled receiver stalls the block only once the next
// result is ready to be loaded.
// Reset (rst, synchronous) clears gains, limits and setpoint to zero, sets
// enable, and zeroes the integral, last error and drive.
module pid_controller_clamped_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] measured, [63:32] step_time
  input  logic [pcc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] opcode
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] drive
  output logic [pcc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // [0] held
  output logic                              m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [pcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pcc_pkg::WORD_BITS-1:0]     cfg_data
);
  import pcc_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t status;

  pcc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  pcc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

endmodule

// ----- sim/tb_pid_controller_clamped_top.sv -----
`timescale 1ns / 1ps

module tb_pid_controller_clamped_top;
  import pcc_pkg::*;

  typedef logic signed [63:0] q64_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] drive;
    logic                 held;
  } pid_result_t;

  typedef enum logic {
    RK_REQ,
    RK_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_sel;
    logic [31:0] reg_val;
    logic        op;
    logic [31:0] meas;
    logic [31:0] dt;
    bit          chk;
    logic [31:0] want_drive;
    bit          want_held;
  } dir_row_t;

  localparam q64_t W_MAX           = (q64_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam q64_t W_MIN           = -W_MAX - 1;
  localparam int   NUM_PHASES      = 12;
  localparam int   PHASE_REQS      = 140;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam int   IDLE_PCT        = 18;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we        = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
  logic [WORD_BITS-1:0]  cfg_data      = '0;

  // Controller model: configuration and loop state
  q64_t gain_p = 0, gain_i = 0, gain_d = 0;
  q64_t lim_lo = 0, lim_hi = 0, int_bound = 0, target = 0;
  bit   run_en = 1'b1;
  q64_t int_acc = 0, prev_err = 0, drive_hold = 0;

  pid_result_t pending_drives[$];
  pid_result_t want;

  int  n_fail = 0, n_checked = 0, n_computed = 0, n_held = 0, n_writes = 0;
  bit  calm = 1'b0;
  int  stall_req = 0, stall_seen = 0, hold_left = 0;

  pid_controller_clamped_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a magnitude with sign to the word range
  function automatic q64_t sat_mag(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = 128'(1) << (WORD_BITS - 1);
    if (mag >= lim) return neg ? W_MIN : W_MAX;
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  // Fixed-point product, truncated toward zero, saturated
  function automatic q64_t qmul_sat(q64_t a, q64_t b);
    logic signed [127:0] prod;
    logic [127:0]        mag;
    prod = a * b;
    mag  = prod[127] ? 128'(-prod) : 128'(prod);
    return sat_mag(prod[127], mag >> FRAC_BITS);
  endfunction

  function automatic void clear_loop_state();
    int_acc    = 0;
    prev_err   = 0;
    drive_hold = 0;
  endfunction

  // One control request: returns the drive it yields and updates loop state
  function automatic pid_result_t pid_step(logic op, logic [31:0] m, logic [31:0] t);
    q64_t meas_s, dt_s, err, acc, p_term, i_term, d_term, diff, dmag, qd, v;
    meas_s = q64_t'($signed(m));
    dt_s   = q64_t'($signed(t));
    if (op == OP_CLEAR) begin
      clear_loop_state();
      n_held++;
      return '{drive: '0, held: 1'b1};
    end
    if (!run_en || dt_s <= 0) begin
      n_held++;
      return '{drive: drive_hold[WORD_BITS-1:0], held: 1'b1};
    end
    n_computed++;
    err    = target - meas_s;
    p_term = qmul_sat(gain_p, err);
    // integral with anti-windup clamp
    acc = int_acc + qmul_sat(err, dt_s);
    if (acc > int_bound) acc = int_bound;
    else if (acc < -int_bound) acc = -int_bound;
    int_acc = acc;
    i_term  = qmul_sat(gain_i, int_acc);
    // derivative: error change over step, toward zero
    diff     = err - prev_err;
    dmag     = (diff < 0) ? -diff : diff;
    qd       = (dmag <<< FRAC_BITS) / dt_s;
    d_term   = qmul_sat(gain_d, sat_mag(diff < 0, 128'(qd)));
    prev_err = err;
    v = p_term + i_term + d_term;
    if (v > W_MAX) v = W_MAX;
    else if (v < W_MIN) v = W_MIN;
    // upper bound tested first, also when the limits are crossed
    if (v > lim_hi) v = lim_hi;
    else if (v < lim_lo) v = lim_lo;
    drive_hold = v;
    return '{drive: v[WORD_BITS-1:0], held: 1'b0};
  endfunction

  function automatic dir_row_t req_row(logic op, logic [31:0] m, logic [31:0] t,
                                       bit chk = 1'b0, logic [31:0] d = '0, bit h = 1'b0);
    return '{kind: RK_REQ, reg_sel: REG_KP, reg_val: '0, op: op, meas: m, dt: t,
             chk: chk, want_drive: d, want_held: h};
  endfunction

  function automatic dir_row_t cfg_row(cfg_reg_t r, logic [31:0] v);
    return '{kind: RK_CFG, reg_sel: r, reg_val: v, op: OP_STEP, meas: '0, dt: '0,
             chk: 1'b0, want_drive: '0, want_held: 1'b0};
  endfunction

  // Q16.16 value: mostly small, some corners, some full range
  function automatic logic [31:0] rnd_q16();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = 32'h0000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0000;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0001_0000;
        endcase
      end
      1, 2: v = $urandom();
      default: begin
        v = $urandom_range(32'h0008_0000);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // Register write; cfg_we stays high until the next request lowers it
  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v;
    @(posedge clk);
    n_writes++;
    case (r)
      REG_KP:        gain_p    = q64_t'($signed(v));
      REG_KI:        gain_i    = q64_t'($signed(v));
      REG_KD:        gain_d    = q64_t'($signed(v));
      REG_OUT_MIN:   lim_lo    = q64_t'($signed(v));
      REG_OUT_MAX:   lim_hi    = q64_t'($signed(v));
      REG_INT_LIMIT: int_bound = q64_t'(v[LIMIT_W-1:0]);
      REG_SETPOINT:  target    = q64_t'($signed(v));
      REG_ENABLE: begin
        run_en = v[0];
        if (!v[0]) clear_loop_state();
      end
      default: ;
    endcase
  endtask

  // Offer one request, with random gaps, and log its expected result
  task automatic send_req(logic op, logic [31:0] m, logic [31:0] t,
                          bit chk = 1'b0, logic [31:0] d = '0, bit h = 1'b0);
    pid_result_t r;
    cfg_we <= 1'b0;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t, m};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    r = pid_step(op, m, t);
    if (chk) r = '{drive: d, held: h};
    pending_drives.push_back(r);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle(int extra);
    s_axis_tvalid <= 1'b0;
    cfg_we        <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (stall_seen != stall_req) begin
      stall_seen    <= stall_req;
      hold_left     <= HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $error("result with nothing pending: drive %h held %b", m_axis_tdata, m_axis_tuser);
        n_fail++;
      end else begin
        want = pending_drives.pop_front();
        n_checked++;
        if (m_axis_tdata[WORD_BITS-1:0] !== want.drive) begin
          $error("drive mismatch: expected %h, actual %h", want.drive,
                 m_axis_tdata[WORD_BITS-1:0]);
          n_fail++;
        end
        if (m_axis_tuser !== want.held) begin
          $error("held mismatch: expected %b, actual %b", want.held, m_axis_tuser);
          n_fail++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t    rows[$];
    logic [31:0] vals [7];
    logic [31:0] lo, hi, m, t, off;
    logic        op;
    bit          after_req;

    // After reset: zero gains and a zero clamp window
    rows.push_back(req_row(OP_STEP, 32'h7FFF_FFFF, 32'h0001_0000, 1, 32'h0, 1'b0));
    rows.push_back(req_row(OP_STEP, 32'h8000_0000, 32'h0000_0001, 1, 32'h0, 1'b0));
    rows.push_back(req_row(OP_STEP, 32'h0001_0000, 32'h0000_0000, 1, 32'h0, 1'b1));
    rows.push_back(req_row(OP_STEP, 32'h0001_0000, 32'h8000_0000, 1, 32'h0, 1'b1));
    rows.push_back(req_row(OP_CLEAR, 32'h0, 32'h0, 1, 32'h0, 1'b1));
    // Extreme kp, ki and setpoint, unit kd: the P and I terms saturate
    rows.push_back(cfg_row(REG_KP, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_KI, 32'h8000_0000));
    rows.push_back(cfg_row(REG_KD, 32'h0001_0000));
    rows.push_back(cfg_row(REG_OUT_MIN, 32'h8000_0000));
    rows.push_back(cfg_row(REG_OUT_MAX, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_INT_LIMIT, 32'h7FFF_FFFF));
    rows.push_back(cfg_row(REG_SETPOINT, 32'h7FFF_FFFF));
    rows.push_back(req_row(OP_STEP, 32'h8000_0000, 32'h7FFF_FFFF));
    rows.push_back(req_row(OP_STEP, 32'h7FFF_FFFF, 32'h0000_0001));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'hFFFF_FFFF));
    // Disable clears the held drive
    rows.push_back(cfg_row(REG_ENABLE, 32'h0));
    rows.push_back(req_row(OP_STEP, 32'h1234_5678, 32'h0001_0000, 1, 32'h0, 1'b1));
    rows.push_back(cfg_row(REG_ENABLE, 32'h1));
    // Moderate gains: integral runs into its limit, drive into out_max
    rows.push_back(cfg_row(REG_KP, 32'h0001_0000));
    rows.push_back(cfg_row(REG_KI, 32'h0000_8000));
    rows.push_back(cfg_row(REG_KD, 32'h0000_4000));
    rows.push_back(cfg_row(REG_INT_LIMIT, 32'h0005_0000));
    rows.push_back(cfg_row(REG_OUT_MIN, 32'hFFF6_0000));
    rows.push_back(cfg_row(REG_OUT_MAX, 32'h0014_0000));
    rows.push_back(cfg_row(REG_SETPOINT, 32'h000A_0000));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h000A_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h0014_0000, 32'h0000_8000));
    rows.push_back(req_row(OP_STEP, 32'hFFEC_0000, 32'h0000_0002));
    rows.push_back(req_row(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1'b1));
    // Crossed clamp limits
    rows.push_back(cfg_row(REG_OUT_MIN, 32'h0005_0000));
    rows.push_back(cfg_row(REG_OUT_MAX, 32'hFFFB_0000));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h0014_0000, 32'h0001_0000));
    rows.push_back(req_row(OP_STEP, 32'h000A_0000, 32'h0001_0000));
    // Zero integral limit
    rows.push_back(cfg_row(REG_INT_LIMIT, 32'h0));
    rows.push_back(req_row(OP_STEP, 32'h0000_0000, 32'h0001_0000));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    after_req = 1'b0;
    foreach (rows[k]) begin
      if (rows[k].kind == RK_CFG) begin
        if (after_req) settle(4);
        write_reg(rows[k].reg_sel, rows[k].reg_val);
        after_req = 1'b0;
      end else begin
        send_req(rows[k].op, rows[k].meas, rows[k].dt, rows[k].chk,
                 rows[k].want_drive, rows[k].want_held);
        after_req = 1'b1;
      end
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle(4);
      if (ph == 0) begin
        vals = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
      end else if (ph == 1) begin
        vals = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF};
      end else begin
        vals[REG_KP] = rnd_q16();
        vals[REG_KI] = rnd_q16();
        vals[REG_KD] = rnd_q16();
        lo = rnd_q16();
        hi = rnd_q16();
        // mostly an ordered window, sometimes crossed
        if ($signed(lo) > $signed(hi) && $urandom_range(4) != 0) begin
          vals[REG_OUT_MIN] = hi;
          vals[REG_OUT_MAX] = lo;
        end else begin
          vals[REG_OUT_MIN] = lo;
          vals[REG_OUT_MAX] = hi;
        end
        case ($urandom_range(3))
          0: vals[REG_INT_LIMIT] = 32'h0;
          1: vals[REG_INT_LIMIT] = $urandom() & 32'h7FFF_FFFF;
          default: vals[REG_INT_LIMIT] = $urandom_range(32'h0010_0000);
        endcase
        vals[REG_SETPOINT] = rnd_q16();
      end
      for (int r = 0; r < 7; r++) write_reg(cfg_reg_t'(r), vals[r]);
      if (ph % 4 == 3) write_reg(REG_ENABLE, 32'h0);
      write_reg(REG_ENABLE, (ph == 4) ? 32'h0 : 32'h1);

      calm <= (ph == 6);
      if (ph == 2) stall_req <= stall_req + 1;

      for (int n = 0; n < PHASE_REQS; n++) begin
        // pause only with a request outstanding, so the wait spans an edge
        if (n > 0 && ((ph == 2 && n == 100) || $urandom_range(299) == 0)) settle(0);
        op = ($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP;
        if ($urandom_range(9) < 7) begin
          off = $urandom_range(32'h0010_0000);
          if ($urandom_range(1)) off = -off;
          m = vals[REG_SETPOINT] + off;
        end else begin
          m = rnd_q16();
        end
        case ($urandom_range(19))
          0: t = 32'h0;
          1: t = $urandom() | 32'h8000_0000;
          2: t = 32'h1;
          3, 4: t = $urandom();
          default: t = $urandom_range(32'h0004_0000, 1);
        endcase
        send_req(op, m, t);
      end
    end

    calm <= 1'b0;
    settle(60);

    $display("Checked %0d results: %0d computed control steps, %0d held or cleared",
             n_checked, n_computed, n_held);
    $display("%0d register writes: extreme and random gains, crossed clamps, %s",
             n_writes, "zero integral limit, disabled loop, long output stall");
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pcc_pkg.sv
rtl/pcc_div.sv
rtl/pcc_dp.sv
rtl/pcc_ctrl.sv
rtl/pid_controller_clamped_top.sv
sim/tb_pid_controller_clamped_top.sv
